[hw/rtl/ssht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssht_pkg
// Shared types and constants for the segment/sphere hit test pipeline.
// ----------------------------------------------------------------------------
package ssht_pkg;

	// Number of register stages from input transfer to result
	localparam int NUM_STAGES = 7;

	// Root test outcome carried down the back half of the pipeline
	typedef struct packed {
		logic direct;  // sign change of f over [0,1]: hit without discriminant
		logic check;   // interior vertex case: hit decided by h^2 >= a*c
	} root_flags_t;

endpackage

[hw/rtl/segment_sphere_hit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_sphere_hit_test
// Exact integer test of a Q8.8 segment against a Q8.8 sphere surface.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one query: segment start,
//   segment vector (end minus start), sphere centre and radius. The output
//   channel (out_valid/out_ready) returns one hit bit per query, in order.
//   Each query passes through every pipeline stage before out_valid rises,
//   and one query is taken every cycle unless a stalled receiver backs the
//   pipeline up. The depth comes from the seven pipeline stages: difference,
//   products, sums a/h/c, root case flags, split partial products of h^2
//   and a*c, their recombination, and the compare.
//   Each stage has its own valid bit and moves when the stage after it is
//   empty or moving, so bubbles close up and a query is still taken while
//   a finished result waits on a stalled receiver. With the pipeline full
//   and out_ready low, in_ready drops and every stage holds its contents.
//   Reset (arst_n low) empties all stages; no result is pending after it.
// ----------------------------------------------------------------------------
module segment_sphere_hit_test #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] start_z,
	input  logic signed [COORD_BITS-1:0] dir_x,
	input  logic signed [COORD_BITS-1:0] dir_y,
	input  logic signed [COORD_BITS-1:0] dir_z,
	input  logic signed [COORD_BITS-1:0] centre_x,
	input  logic signed [COORD_BITS-1:0] centre_y,
	input  logic signed [COORD_BITS-1:0] centre_z,
	input  logic        [COORD_BITS-2:0] sphere_radius,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit
);

	localparam int N  = COORD_BITS;
	localparam int PW = 2 * N + 2;  // product width
	localparam int SW = 2 * N + 4;  // a, h, c width
	localparam int FW = 2 * N + 5;  // f(1) and a+h width
	localparam int MW = 2 * N;      // |h| and a magnitude width
	localparam int CW = 2 * N + 2;  // c magnitude width
	localparam int DW = 4 * N + 2;  // h^2 and a*c width
	localparam int NS = ssht_pkg::NUM_STAGES;

	// Stage valid bits and per-stage advance
	logic [NS:1] valid_q;
	logic [NS:1] adv;

	// Stage 1: difference p = start - centre
	logic signed [N-1:0] d_s1 [3];
	logic signed [N:0]   p_s1 [3];
	logic        [N-2:0] r_s1;

	// Stage 2: products
	logic signed [PW-1:0] dd_s2 [3];
	logic signed [PW-1:0] dp_s2 [3];
	logic signed [PW-1:0] pp_s2 [3];
	logic        [2*N-3:0] rr_s2;

	// Stage 3: quadratic coefficients
	logic signed [SW-1:0] a_s3;
	logic signed [SW-1:0] h_s3;
	logic signed [SW-1:0] c_s3;

	// Stage 4: root case flags and magnitudes
	ssht_pkg::root_flags_t flags_s4;
	logic [MW-1:0] hm_s4;
	logic [MW-1:0] am_s4;
	logic [CW-1:0] cm_s4;

	// Stage 5: partial products
	ssht_pkg::root_flags_t flags_s5;
	logic [2*N-1:0] hhh_s5;
	logic [2*N-1:0] hhl_s5;
	logic [2*N-1:0] hll_s5;
	logic [2*N+1:0] ahch_s5;
	logic [2*N-1:0] ahcl_s5;
	logic [2*N+1:0] alch_s5;
	logic [2*N-1:0] alcl_s5;

	// Stage 6: recombined h^2 and a*c
	ssht_pkg::root_flags_t flags_s6;
	logic [DW-1:0] h2_s6;
	logic [DW-1:0] ac_s6;

	// Stage 7: result
	logic hit_s7;

	// Stage 4 combinational terms
	logic signed [FW-1:0] f1;
	logic signed [FW-1:0] ah;
	logic signed [FW-1:0] hneg;
	logic a_nz, c_le0, c_ge0, c_gt0, f_le0, f_ge0, f_gt0, h_le0, ah_ge0;

	// Advance a stage when it is empty or the stage after it advances
	always_comb begin
		adv[NS] = ~valid_q[NS] | out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			adv[k] = ~valid_q[k] | adv[k+1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = valid_q[NS];
	assign hit       = hit_s7;

	// Move valid bits down the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Stage 1: register vector, offset from centre and radius
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			d_s1[0] <= dir_x;
			d_s1[1] <= dir_y;
			d_s1[2] <= dir_z;
			p_s1[0] <= (N+1)'(start_x) - (N+1)'(centre_x);
			p_s1[1] <= (N+1)'(start_y) - (N+1)'(centre_y);
			p_s1[2] <= (N+1)'(start_z) - (N+1)'(centre_z);
			r_s1    <= sphere_radius;
		end
	end

	// Stage 2: per-axis products and radius squared
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int k = 0; k < 3; k++) begin
				dd_s2[k] <= PW'(d_s1[k]) * PW'(d_s1[k]);
				dp_s2[k] <= PW'(d_s1[k]) * PW'(p_s1[k]);
				pp_s2[k] <= PW'(p_s1[k]) * PW'(p_s1[k]);
			end
			rr_s2 <= (2*N-2)'(r_s1) * (2*N-2)'(r_s1);
		end
	end

	// Stage 3: sum axes into a = d.d, h = d.p, c = p.p - r^2
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			a_s3 <= SW'(dd_s2[0]) + SW'(dd_s2[1]) + SW'(dd_s2[2]);
			h_s3 <= SW'(dp_s2[0]) + SW'(dp_s2[1]) + SW'(dp_s2[2]);
			c_s3 <= SW'(pp_s2[0]) + SW'(pp_s2[1]) + SW'(pp_s2[2]) - SW'(rr_s2);
		end
	end

	// Stage 4 logic: f(1) = a + 2h + c and the sign tests
	always_comb begin
		f1     = FW'(a_s3) + FW'(h_s3) + FW'(h_s3) + FW'(c_s3);
		ah     = FW'(a_s3) + FW'(h_s3);
		hneg   = FW'(0) - FW'(h_s3);
		a_nz   = (a_s3 != '0);
		c_le0  = c_s3[SW-1] | (c_s3 == '0);
		c_ge0  = ~c_s3[SW-1];
		c_gt0  = ~c_le0;
		f_le0  = f1[FW-1] | (f1 == '0);
		f_ge0  = ~f1[FW-1];
		f_gt0  = ~f_le0;
		h_le0  = h_s3[SW-1] | (h_s3 == '0);
		ah_ge0 = ~ah[FW-1];
	end

	// Stage 4: classify the root case; keep magnitudes for the discriminant
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			flags_s4.direct <= a_nz & ((c_le0 & f_ge0) | (c_ge0 & f_le0));
			flags_s4.check  <= a_nz & c_gt0 & f_gt0 & h_le0 & ah_ge0;
			hm_s4 <= hneg[MW-1:0];
			am_s4 <= a_s3[MW-1:0];
			cm_s4 <= c_s3[CW-1:0];
		end
	end

	// Stage 5: split h^2 and a*c into half-width partial products
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			flags_s5 <= flags_s4;
			hhh_s5  <= (2*N)'(hm_s4[MW-1:N]) * (2*N)'(hm_s4[MW-1:N]);
			hhl_s5  <= (2*N)'(hm_s4[MW-1:N]) * (2*N)'(hm_s4[N-1:0]);
			hll_s5  <= (2*N)'(hm_s4[N-1:0]) * (2*N)'(hm_s4[N-1:0]);
			ahch_s5 <= (2*N+2)'(am_s4[MW-1:N]) * (2*N+2)'(cm_s4[CW-1:N]);
			ahcl_s5 <= (2*N)'(am_s4[MW-1:N]) * (2*N)'(cm_s4[N-1:0]);
			alch_s5 <= (2*N+2)'(am_s4[N-1:0]) * (2*N+2)'(cm_s4[CW-1:N]);
			alcl_s5 <= (2*N)'(am_s4[N-1:0]) * (2*N)'(cm_s4[N-1:0]);
		end
	end

	// Stage 6: recombine partial products at their weights
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			flags_s6 <= flags_s5;
			h2_s6 <= (DW'(hhh_s5) << (2 * N)) + (DW'(hhl_s5) << (N + 1)) + DW'(hll_s5);
			ac_s6 <= (DW'(ahch_s5) << (2 * N))
				+ ((DW'(ahcl_s5) + DW'(alch_s5)) << N)
				+ DW'(alcl_s5);
		end
	end

	// Stage 7: discriminant sign decides the interior case
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			hit_s7 <= flags_s6.direct | (flags_s6.check & (h2_s6 >= ac_s6));
		end
	end

endmodule

[test/segment_sphere_hit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_sphere_hit_checker
// Watches both channels of the segment/sphere hit test. It predicts the hit
// bit of every accepted query with exact wide integer arithmetic. It then
// compares each returned hit, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_sphere_hit_checker #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] start_z,
	input  logic signed [COORD_BITS-1:0] dir_x,
	input  logic signed [COORD_BITS-1:0] dir_y,
	input  logic signed [COORD_BITS-1:0] dir_z,
	input  logic signed [COORD_BITS-1:0] centre_x,
	input  logic signed [COORD_BITS-1:0] centre_y,
	input  logic signed [COORD_BITS-1:0] centre_z,
	input  logic        [COORD_BITS-2:0] sphere_radius,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         hit,
	output int                           fail_count,
	output int                           pending
);

	// Wide enough for h^2 and a*c at any coordinate width up to about 30 bits
	typedef logic signed [127:0] wide_t;

	logic hit_expected_q[$];
	logic hit_want;
	int   mismatch_count = 0;
	int   queued = 0;

	assign fail_count = mismatch_count;
	assign pending    = queued;

	// Exact root test of f(t) = a t^2 + 2 h t + c over t in [0,1]
	function automatic logic segment_meets_sphere(
		input logic signed [COORD_BITS-1:0] sx, sy, sz,
		input logic signed [COORD_BITS-1:0] dx, dy, dz,
		input logic signed [COORD_BITS-1:0] cx, cy, cz,
		input logic        [COORD_BITS-2:0] rad
	);
		wide_t px, py, pz, wx, wy, wz, t, r, a, h, c, f1, disc;
		logic  meets;
		wx = dx;
		wy = dy;
		wz = dz;
		px = sx;
		t  = cx;
		px = px - t;
		py = sy;
		t  = cy;
		py = py - t;
		pz = sz;
		t  = cz;
		pz = pz - t;
		r  = rad;
		a  = wx * wx + wy * wy + wz * wz;
		h  = wx * px + wy * py + wz * pz;
		c  = px * px + py * py + pz * pz - r * r;
		meets = 1'b0;
		// A zero-length segment never meets the surface
		if (a != 0) begin
			f1 = a + 2 * h + c;
			if ((c <= 0 && f1 >= 0) || (c >= 0 && f1 <= 0)) begin
				meets = 1'b1;
			end else if (c > 0 && f1 > 0 && h <= 0 && a + h >= 0) begin
				// Both ends outside, vertex inside the span: decide on the discriminant
				disc  = h * h - a * c;
				meets = (disc >= 0);
			end
		end
		return meets;
	endfunction

	// Check results first so that a stray result cannot match a query taken
	// at the same edge, then queue the prediction for a new transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_expected_q.delete();
			queued = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (hit_expected_q.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result with no query outstanding, hit=%b", $realtime, hit);
					mismatch_count++;
				end else begin
					hit_want = hit_expected_q.pop_front();
					if (hit !== hit_want) begin
						if (mismatch_count < 10)
							$display("%0t: hit mismatch, expected %b, actual %b",
								$realtime, hit_want, hit);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready)
				hit_expected_q.push_back(segment_meets_sphere(start_x, start_y, start_z,
					dir_x, dir_y, dir_z, centre_x, centre_y, centre_z, sphere_radius));
			queued = hit_expected_q.size();
		end
	end

endmodule

[test/tb_segment_sphere_hit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_sphere_hit_test
// Drives queries into the segment/sphere hit test and gives the verdict.
// A directed set covers range extremes, zero-length segments, segments wholly
// inside, tangents, endpoints on the surface and point spheres. The random
// part mixes raw noise with constructed near-surface geometry. Both sides
// idle at random. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb_segment_sphere_hit_test;

	localparam int CB          = 16;
	localparam int IDLE_PCT    = 29;
	localparam int RANDOM_CNT  = 830;
	localparam int STALL_LIMIT = 2000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [CB-1:0] start_x  = '0;
	logic signed [CB-1:0] start_y  = '0;
	logic signed [CB-1:0] start_z  = '0;
	logic signed [CB-1:0] dir_x    = '0;
	logic signed [CB-1:0] dir_y    = '0;
	logic signed [CB-1:0] dir_z    = '0;
	logic signed [CB-1:0] centre_x = '0;
	logic signed [CB-1:0] centre_y = '0;
	logic signed [CB-1:0] centre_z = '0;
	logic        [CB-2:0] sphere_radius = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 hit;

	int   fail_count;
	int   pending;
	logic tx_no_idle = 1'b0;

	// Clock: 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	segment_sphere_hit_test #(.COORD_BITS(CB)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_x      (start_x),
		.start_y      (start_y),
		.start_z      (start_z),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.centre_z     (centre_z),
		.sphere_radius(sphere_radius),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit)
	);

	segment_sphere_hit_checker #(.COORD_BITS(CB)) hit_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_x      (start_x),
		.start_y      (start_y),
		.start_z      (start_z),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.centre_z     (centre_z),
		.sphere_radius(sphere_radius),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Offer one query, idling first at random; return at the falling edge
	// after the transfer with valid still high
	task automatic send_query(input int sx, sy, sz, dx, dy, dz, cx, cy, cz, rad);
		while (!tx_no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		start_x       <= sx[CB-1:0];
		start_y       <= sy[CB-1:0];
		start_z       <= sz[CB-1:0];
		dir_x         <= dx[CB-1:0];
		dir_y         <= dy[CB-1:0];
		dir_z         <= dz[CB-1:0];
		centre_x      <= cx[CB-1:0];
		centre_y      <= cy[CB-1:0];
		centre_z      <= cz[CB-1:0];
		sphere_radius <= rad[CB-2:0];
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic int spread(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Receiver: random stalls, one long hold-off to fill the pipeline,
	// and a stretch with no stalls
	initial begin : receiver
		int rx_cycle;
		rx_cycle = 0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle >= 250 && rx_cycle < 330)
				out_ready <= 1'b0;
			else if (rx_cycle >= 900 && rx_cycle < 1300)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Watchdog: end the run if nothing transfers for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	// Stimulus and verdict
	initial begin : stimulus
		int s[3], d[3], c[3];
		int rad, k, ax, kind;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Range extremes
		send_query(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768, 32767);
		send_query(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767, 0);
		send_query(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 32767);
		send_query(32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
		send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, 32767);
		// Zero-length segment, inside and on the surface
		send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 4096);
		send_query(256, 0, 0, 0, 0, 0, 0, 0, 0, 256);
		// Segment wholly inside
		send_query(-256, 0, 0, 512, 0, 0, 0, 0, 0, 4096);
		// Straight through the centre
		send_query(-2048, 0, 0, 4096, 0, 0, 0, 0, 0, 512);
		// Tangent at mid-span, then one unit off
		send_query(-512, 256, 0, 1024, 0, 0, 0, 0, 0, 256);
		send_query(-512, 257, 0, 1024, 0, 0, 0, 0, 0, 256);
		// Start on the surface pointing away, end on the surface
		send_query(256, 0, 0, 512, 0, 0, 0, 0, 0, 256);
		send_query(0, -1024, 0, 0, 768, 0, 0, 0, 0, 256);
		// Point sphere: hit exactly, then miss by one
		send_query(-100, -200, 300, 200, 400, -600, 0, 0, 0, 0);
		send_query(-100, -200, 300, 200, 401, -600, 0, 0, 0, 0);
		// Vertex beyond the span and far miss
		send_query(-4096, 300, 0, 1024, 0, 0, 0, 0, 0, 256);
		send_query(10000, 10000, 10000, 100, 100, 100, -10000, -10000, -10000, 100);
		// Largest radius around a distant centre
		send_query(0, 0, 0, 1, 1, 1, 20000, 20000, 20000, 32767);

		for (int i = 0; i < RANDOM_CNT; i++) begin
			tx_no_idle <= (i >= 300 && i < 450);
			// Drain everything once before continuing
			if (i == 600) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			kind = $urandom_range(0, 9);
			for (int j = 0; j < 3; j++) begin
				c[j] = spread(8192);
				s[j] = c[j] + spread(6000);
				d[j] = spread(8192);
			end
			rad = $urandom_range(1, 4095);
			ax  = $urandom_range(0, 2);
			k   = $urandom_range(1, 4095);
			case (kind)
				0, 1: begin
					// Raw noise over every bit
					for (int j = 0; j < 3; j++) begin
						s[j] = $urandom();
						d[j] = $urandom();
						c[j] = $urandom();
					end
					rad = $urandom();
				end
				2, 3: begin
					for (int j = 0; j < 3; j++) begin
						s[j] = spread(2048);
						d[j] = spread(2048);
						c[j] = spread(2048);
					end
					rad = $urandom_range(0, 2047);
				end
				7: begin
					// Start on the surface; sometimes run to the opposite pole
					for (int j = 0; j < 3; j++) s[j] = c[j];
					s[ax] = ($urandom_range(0, 1)) ? c[ax] + rad : c[ax] - rad;
					if ($urandom_range(0, 1)) begin
						for (int j = 0; j < 3; j++) d[j] = 0;
						d[ax] = 2 * (c[ax] - s[ax]);
					end
				end
				8: begin
					if ($urandom_range(0, 1)) begin
						for (int j = 0; j < 3; j++) d[j] = 0;
					end else begin
						// Point sphere crossed at mid-span, or missed by one
						rad = 0;
						for (int j = 0; j < 3; j++) begin
							d[j] = 2 * spread(4000);
							s[j] = c[j] - d[j] / 2;
						end
						if ($urandom_range(0, 1)) d[ax] = d[ax] + 1;
					end
				end
				9: begin
					// Tangent at mid-span, or one unit outside
					for (int j = 0; j < 3; j++) begin
						s[j] = c[j];
						d[j] = 0;
					end
					s[ax] = c[ax] - k;
					d[ax] = 2 * k;
					s[(ax + 1) % 3] = c[(ax + 1) % 3] + rad + $urandom_range(0, 1);
				end
				default: ;
			endcase
			send_query(s[0], s[1], s[2], d[0], d[1], d[2], c[0], c[1], c[2], rad);
		end
		in_valid   <= 1'b0;
		tx_no_idle <= 1'b0;

		// Drain, then allow the pipeline depth for any stray result
		while (pending != 0) @(posedge clk);
		repeat (ssht_pkg::NUM_STAGES * 4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ssht_pkg.sv
hw/rtl/segment_sphere_hit_test.sv
test/segment_sphere_hit_checker.sv
test/tb_segment_sphere_hit_test.sv
